@@ rtl/core/multi_mode_morse_keyer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Morse keyer
// Concurrent property wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_MORSE_KEYER_MACROS_SVH
`define MULTI_MODE_MORSE_KEYER_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define MMK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("keyer assertion failed");

// Condition in one cycle implies a consequence in the next.
`define MMK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyer assertion failed");

`else

`define MMK_ASSERT(lbl, clk, rst_n, prop)

`define MMK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/mmk_pkg.sv @@
// ----------------------------------------------------------------------------
// mmk_pkg
// Mode codes, register indexes, element and opcode codes and default constants of the Morse keyer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmk_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [11:0] DIT_MS_RESET = 12'd100;

	// keyer_mode codes; 9..15 act as straight
	localparam logic [3:0] MODE_STRAIGHT   = 4'd0;
	localparam logic [3:0] MODE_BUG        = 4'd1;
	localparam logic [3:0] MODE_ELBUG      = 4'd2;
	localparam logic [3:0] MODE_SINGLE_DOT = 4'd3;
	localparam logic [3:0] MODE_ULTIMATIC  = 4'd4;
	localparam logic [3:0] MODE_IAMBIC     = 4'd5;
	localparam logic [3:0] MODE_IAMBIC_A   = 4'd6;
	localparam logic [3:0] MODE_IAMBIC_B   = 4'd7;
	localparam logic [3:0] MODE_KEYAHEAD   = 4'd8;

	// configuration register indexes
	localparam logic REG_KEYER_MODE = 1'b0;
	localparam logic REG_DIT_MS     = 1'b1;

	// paddle / relay codes
	localparam logic ELEM_DIT = 1'b0;
	localparam logic ELEM_DAH = 1'b1;

	// input opcodes
	localparam logic OP_PADDLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

endpackage

@@ rtl/core/multi_mode_morse_keyer.sv @@
// ----------------------------------------------------------------------------
// multi_mode_morse_keyer
// Nine-mode Morse keyer: paddle events and 1 ms ticks in, relay keying out.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle while the result register is free or drains;
//   the whole state update fits between the input port and the result register.
// Reset: arst_n clears all control state; mode goes to straight, dit to 100 ms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_mode_morse_keyer_macros.svh"

module multi_mode_morse_keyer #(
	parameter int QUEUE_DEPTH = mmk_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,

	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] paddle, [1] pressed, [7:2] zero
	input  logic        s_tuser,   // [0] opcode

	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] changed, [1] tx_on, [2] relay, [7:3] zero
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// press memory: shift register of 1-bit paddle codes, front at bit 0
	typedef struct packed {
		logic [QUEUE_DEPTH-1:0] bits;
		logic [CW-1:0]          cnt;
	} mem_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [3:0]  mode_q;
	logic [11:0] dit_q;
	logic        cfg_fire;
	logic        mode_wr;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign mode_wr   = cfg_fire && (cfg_index == mmk_pkg::REG_KEYER_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmk_pkg::MODE_STRAIGHT;
			dit_q  <= mmk_pkg::DIT_MS_RESET;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				mmk_pkg::REG_KEYER_MODE: mode_q <= cfg_data[3:0];
				mmk_pkg::REG_DIT_MS:     dit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// keyer state
	// ------------------------------------------------------------------
	logic [1:0]  relay_closed_q;
	logic [1:0]  paddle_down_q;
	logic        timer_armed_q;
	logic [13:0] ticks_left_q;
	logic        rep_v_q;        // repeat choice present
	logic        rep_q;
	logic        se_v_q;         // element being sent
	logic        se_q;
	logic [QUEUE_DEPTH-1:0] mem_bits_q;  // no reset: read only below the count
	logic [CW-1:0]          mem_cnt_q;

	// ------------------------------------------------------------------
	// memory helpers
	// ------------------------------------------------------------------
	function automatic mem_t mem_add(mem_t m, logic v, logic uniq);
		logic hit;
		mem_t r;
		r   = m;
		hit = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (uniq && (CW'(i) < m.cnt) && (m.bits[i] == v))
				hit = 1'b1;
		end
		if (!hit && (m.cnt < CW'(QUEUE_DEPTH))) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (CW'(i) == m.cnt)
					r.bits[i] = v;
			end
			r.cnt = m.cnt + 1'b1;
		end
		return r;
	endfunction

	// caller checks cnt != 0 and reads bits[0] first
	function automatic mem_t mem_pop(mem_t m);
		mem_t r;
		r.bits = m.bits >> 1;
		r.cnt  = m.cnt - 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// next-state logic for one item
	// ------------------------------------------------------------------
	logic        in_fire;
	logic        op;
	logic        key;
	logic        pr;
	logic        straight;
	logic [11:0] dit_len;
	logic [13:0] dah_len;

	logic [1:0]  rc_n;
	logic [1:0]  pd_n;
	logic        ta_n;
	logic [13:0] tl_n;
	logic        rep_v_n;
	logic        rep_n;
	logic        se_v_n;
	logic        se_n;
	mem_t        mem_n;
	logic        drv_r;
	logic        nx_v;
	logic        nx;
	logic        it_v;
	logic        it;
	logic        res_changed;
	logic        res_tx;
	logic        res_relay;

	assign op  = s_tuser;
	assign key = s_tdata[0];
	assign pr  = s_tdata[1];

	assign straight = (mode_q == mmk_pkg::MODE_STRAIGHT) || (mode_q > mmk_pkg::MODE_KEYAHEAD);
	assign dit_len  = (dit_q == 12'd0) ? 12'd1 : dit_q;
	assign dah_len  = {1'b0, dit_len, 1'b0} + {2'b00, dit_len};

	always_comb begin
		rc_n    = relay_closed_q;
		pd_n    = paddle_down_q;
		ta_n    = timer_armed_q;
		tl_n    = ticks_left_q;
		rep_v_n = rep_v_q;
		rep_n   = rep_q;
		se_v_n  = se_v_q;
		se_n    = se_q;
		mem_n   = '{bits: mem_bits_q, cnt: mem_cnt_q};
		drv_r   = 1'b0;
		nx_v    = 1'b0;
		nx      = 1'b0;
		it_v    = 1'b0;
		it      = 1'b0;

		if (op == mmk_pkg::OP_PADDLE) begin
			if (straight) begin
				rc_n[key] = pr;
				drv_r     = key;
			end else if (mode_q == mmk_pkg::MODE_BUG) begin
				// dit paddle runs the timer, dah paddle keys directly
				pd_n[key] = pr;
				if (key == mmk_pkg::ELEM_DIT) begin
					if (!timer_armed_q) begin
						ta_n = 1'b1;
						tl_n = '0;
					end
				end else begin
					rc_n[key] = pr;
					drv_r     = key;
				end
			end else begin
				if (pr) begin
					if (mode_q == mmk_pkg::MODE_KEYAHEAD)
						mem_n = mem_add(mem_n, key, 1'b0);
					else if (mode_q == mmk_pkg::MODE_ULTIMATIC ||
						mode_q == mmk_pkg::MODE_IAMBIC_B)
						mem_n = mem_add(mem_n, key, 1'b1);
					else if ((mode_q == mmk_pkg::MODE_SINGLE_DOT ||
						mode_q == mmk_pkg::MODE_IAMBIC_A) && key == mmk_pkg::ELEM_DIT)
						mem_n = mem_add(mem_n, mmk_pkg::ELEM_DIT, 1'b1);
				end
				pd_n[key] = pr;
				if (pr) begin
					rep_v_n = 1'b1;
					rep_n   = key;
					if (!timer_armed_q) begin
						ta_n = 1'b1;
						tl_n = '0;
					end
				end else begin
					// fall back to whichever paddle is still held, dit first
					rep_v_n = pd_n[0] | pd_n[1];
					rep_n   = !pd_n[0];
				end
			end
		end else if (!straight && timer_armed_q) begin
			if (ticks_left_q > 14'd1) begin
				tl_n = ticks_left_q - 14'd1;
			end else if (mode_q == mmk_pkg::MODE_BUG) begin
				// automatic dits: toggle relay 0 every dit time
				if (relay_closed_q[0]) begin
					rc_n[0] = 1'b0;
					tl_n    = {2'b00, dit_len};
				end else if (paddle_down_q[0]) begin
					rc_n[0] = 1'b1;
					tl_n    = {2'b00, dit_len};
				end else begin
					ta_n = 1'b0;
				end
			end else if (se_v_q) begin
				// element done: open relay, one dit of space
				rc_n[se_q] = 1'b0;
				drv_r      = se_q;
				se_v_n     = 1'b0;
				tl_n       = {2'b00, dit_len};
			end else begin
				// pick the next element
				unique case (mode_q) inside
					mmk_pkg::MODE_SINGLE_DOT: begin
						if (mem_n.cnt != '0) begin
							nx_v  = 1'b1;
							nx    = mem_n.bits[0];
							mem_n = mem_pop(mem_n);
						end else if (paddle_down_q[1]) begin
							nx_v = 1'b1;
							nx   = mmk_pkg::ELEM_DAH;
						end else if (paddle_down_q[0]) begin
							nx_v = 1'b1;
							nx   = mmk_pkg::ELEM_DIT;
						end
					end
					mmk_pkg::MODE_ULTIMATIC, mmk_pkg::MODE_KEYAHEAD: begin
						if (mem_n.cnt != '0) begin
							nx_v  = 1'b1;
							nx    = mem_n.bits[0];
							mem_n = mem_pop(mem_n);
						end else begin
							nx_v = (paddle_down_q != 2'b00) && rep_v_q;
							nx   = rep_q;
						end
					end
					mmk_pkg::MODE_IAMBIC: begin
						nx_v = (paddle_down_q != 2'b00) && rep_v_q;
						nx   = rep_q;
						if ((paddle_down_q == 2'b11) && rep_v_q)
							rep_n = !rep_q;
					end
					mmk_pkg::MODE_IAMBIC_A: begin
						it_v = (paddle_down_q != 2'b00) && rep_v_q;
						it   = rep_q;
						if ((paddle_down_q == 2'b11) && rep_v_q)
							rep_n = !rep_q;
						if (mem_n.cnt != '0) begin
							nx_v  = 1'b1;
							nx    = mem_n.bits[0];
							mem_n = mem_pop(mem_n);
						end else begin
							nx_v = it_v;
							nx   = it;
						end
					end
					mmk_pkg::MODE_IAMBIC_B: begin
						// held paddles enter memory first, then take the front
						if (paddle_down_q[0])
							mem_n = mem_add(mem_n, mmk_pkg::ELEM_DIT, 1'b1);
						if (paddle_down_q[1])
							mem_n = mem_add(mem_n, mmk_pkg::ELEM_DAH, 1'b1);
						if (mem_n.cnt != '0) begin
							nx_v  = 1'b1;
							nx    = mem_n.bits[0];
							mem_n = mem_pop(mem_n);
						end
					end
					default: begin
						nx_v = (paddle_down_q != 2'b00) && rep_v_q;
						nx   = rep_q;
					end
				endcase

				if (nx_v) begin
					tl_n     = nx ? dah_len : {2'b00, dit_len};
					se_v_n   = 1'b1;
					se_n     = nx;
					rc_n[nx] = 1'b1;
					drv_r    = nx;
				end else begin
					ta_n = 1'b0;
				end
			end
		end

		// at most one relay is driven per item, so a change of the OR is its doing
		res_tx      = |rc_n;
		res_changed = (|relay_closed_q) != res_tx;
		res_relay   = res_changed & drv_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_closed_q <= '0;
			paddle_down_q  <= '0;
			timer_armed_q  <= 1'b0;
			ticks_left_q   <= '0;
			rep_v_q        <= 1'b0;
			rep_q          <= 1'b0;
			se_v_q         <= 1'b0;
			se_q           <= 1'b0;
			mem_cnt_q      <= '0;
		end else if (mode_wr) begin
			// new mode starts from a clean slate
			relay_closed_q <= '0;
			paddle_down_q  <= '0;
			timer_armed_q  <= 1'b0;
			ticks_left_q   <= '0;
			rep_v_q        <= 1'b0;
			rep_q          <= 1'b0;
			se_v_q         <= 1'b0;
			se_q           <= 1'b0;
			mem_cnt_q      <= '0;
		end else if (in_fire) begin
			relay_closed_q <= rc_n;
			paddle_down_q  <= pd_n;
			timer_armed_q  <= ta_n;
			ticks_left_q   <= tl_n;
			rep_v_q        <= rep_v_n;
			rep_q          <= rep_n;
			se_v_q         <= se_v_n;
			se_q           <= se_n;
			mem_cnt_q      <= mem_n.cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			mem_bits_q <= mem_n.bits;
	end

	// ------------------------------------------------------------------
	// result register: takes a new item whenever the slot is empty or drains this cycle
	// ------------------------------------------------------------------
	logic       m_valid_q;
	logic [2:0] m_data_q;

	assign s_tready = !m_valid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, m_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (in_fire)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			m_data_q <= {res_relay, res_tx, res_changed};
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`MMK_ASSERT(a_mem_bound, clk, arst_n, mem_cnt_q <= CW'(QUEUE_DEPTH))
	`MMK_ASSERT(a_elem_keyed, clk, arst_n, !se_v_q || (relay_closed_q[se_q] && timer_armed_q))
	`MMK_ASSERT(a_straight_idle, clk, arst_n, !straight || !timer_armed_q)
	`MMK_ASSERT_NEXT(a_tx_level, clk, arst_n, in_fire && !mode_wr, m_tdata[1] == (|relay_closed_q))

endmodule
